### hdl/bdcs_pkg.sv
package bdcs_pkg;

    localparam int MAP_W = 37;
    localparam int CH_W  = 6;
    localparam int EVT_W = 16;
    localparam int HOP_W = 5;

    typedef enum logic [1:0] {
        CMD_START   = 2'd0,
        CMD_ADVANCE = 2'd1,
        CMD_MAP_REQ = 2'd2
    } cmd_t;

    typedef enum logic {
        REG_HOP_INCREMENT = 1'b0,
        REG_INITIAL_MAP   = 1'b1
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COUNT,
        ST_APPLY,
        ST_HOP,
        ST_MOD,
        ST_FIND,
        ST_RESULT
    } state_t;

    typedef enum logic {
        OP_START,
        OP_MAP
    } op_t;

    typedef struct packed {
        logic [1:0]       command;
        logic [MAP_W-1:0] new_channel_map;
        logic [EVT_W-1:0] instant;
    } req_t;

    typedef struct packed {
        logic [CH_W-1:0]  data_channel;
        logic [CH_W-1:0]  raw_channel;
        logic [EVT_W-1:0] event_count;
        logic             map_switched;
        logic             status;
    } result_t;

endpackage

### hdl/bdcs_chan_if.sv
interface bdcs_chan_if #(parameter type payload_t = logic);

    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);

endinterface

### hdl/ble_data_channel_selector.sv
// Data channel selector for the slave side of a BLE link layer (channel selection
// algorithm 1). Requests arrive on the req channel (valid/ready, payload req_t):
// start a connection, advance one connection event, or post a channel map
// request. Every request yields exactly one result on the res channel (result_t):
// the mapped and unmapped channel, the event counter, a map switch flag and status.
// The user writes the hop increment and initial channel map via cfg_we, cfg_index
// and cfg_data only while no request is in progress; the block does not enforce it.
// Operation: one request is worked at a time; req.ready is high only when idle. A
// request holds the block from its accepting edge until it is idle again, and its
// result becomes valid as it goes idle. An unused command goes straight to its
// result; a map request first runs a one-bit-per-cycle popcount over the channel
// map. An advance runs the modulo steps, and a start runs the popcount before them:
// a single shared subtractor reduces the hop sum modulo the channel count and, for
// an unused channel, the channel modulo the used count, one subtraction per cycle;
// the bit scan then walks the map one channel per cycle.
// The result sits in an output register, so a stalled receiver only holds the block
// once a second result is ready to be written behind it.
// Reset leaves the full map active (37 channels by default), no pending map and a zero event counter.
module ble_data_channel_selector #(
    parameter int NUM_CHANNELS = 37
) (
    input  logic                              clk,
    input  logic                              rst_n,
    bdcs_chan_if.sink                         req,
    bdcs_chan_if.source                       res,
    input  logic                              cfg_we,
    input  bdcs_pkg::cfg_reg_t                cfg_index,
    input  logic [bdcs_pkg::MAP_W-1:0]        cfg_data
);
    import bdcs_pkg::*;

    // Channels beyond the map width can never be used.
    localparam int SCAN_LEN = (NUM_CHANNELS < MAP_W) ? NUM_CHANNELS : MAP_W;
    localparam logic [CH_W-1:0] LAST_IDX = CH_W'(SCAN_LEN - 1);
    localparam logic [CH_W:0] NUM_CH = (CH_W + 1)'(NUM_CHANNELS);
    localparam logic [MAP_W-1:0] CHAN_MASK = {MAP_W{1'b1}} >> (MAP_W - SCAN_LEN);
    localparam logic [CH_W-1:0] RESET_COUNT = CH_W'(SCAN_LEN);
    localparam logic [HOP_W-1:0] RESET_HOP = HOP_W'(5);

    state_t            state_reg, state_next;
    op_t               op_reg, op_next;
    logic [HOP_W-1:0]  hop_reg, hop_next;
    logic [MAP_W-1:0]  init_map_reg, init_map_next;
    logic [CH_W-1:0]   unmapped_reg, unmapped_next;
    logic [CH_W-1:0]   mapped_reg, mapped_next;
    logic [EVT_W-1:0]  evt_reg, evt_next;
    logic [MAP_W-1:0]  active_map_reg, active_map_next;
    logic [CH_W-1:0]   active_cnt_reg, active_cnt_next;
    logic [MAP_W-1:0]  pend_map_reg, pend_map_next;
    logic [CH_W-1:0]   pend_cnt_reg, pend_cnt_next;
    logic [EVT_W-1:0]  pend_inst_reg, pend_inst_next;
    logic              pend_valid_reg, pend_valid_next;
    logic [MAP_W-1:0]  work_map_reg, work_map_next;
    logic [EVT_W-1:0]  req_inst_reg, req_inst_next;
    logic [CH_W-1:0]   scan_idx_reg, scan_idx_next;
    logic [CH_W-1:0]   cnt_reg, cnt_next;
    logic [CH_W:0]     work_val_reg, work_val_next;
    logic [CH_W:0]     divisor_reg, divisor_next;
    logic              mod_second_reg, mod_second_next;
    logic              switched_reg, switched_next;
    logic              status_reg, status_next;
    logic              out_valid_reg, out_valid_next;
    result_t           out_data_reg, out_data_next;

    logic [CH_W+1:0]   sub_res;
    logic              sub_ge;
    logic              chan_used;
    logic              scan_bit;
    logic [EVT_W-1:0]  evt_inc;
    logic              accept;

    // Shared compare-and-subtract unit for both modulo reductions.
    assign sub_res   = {1'b0, work_val_reg} - {1'b0, divisor_reg};
    assign sub_ge    = ~sub_res[CH_W+1];
    assign chan_used = (work_val_reg < (CH_W + 1)'(MAP_W))
                       && active_map_reg[work_val_reg[CH_W-1:0]];
    assign scan_bit  = work_map_reg[scan_idx_reg];
    assign evt_inc   = evt_reg + EVT_W'(1);
    assign accept    = req.valid && req.ready;

    assign req.ready = (state_reg == ST_IDLE);
    assign res.valid = out_valid_reg;
    assign res.data  = out_data_reg;

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        hop_next        = hop_reg;
        init_map_next   = init_map_reg;
        unmapped_next   = unmapped_reg;
        mapped_next     = mapped_reg;
        evt_next        = evt_reg;
        active_map_next = active_map_reg;
        active_cnt_next = active_cnt_reg;
        pend_map_next   = pend_map_reg;
        pend_cnt_next   = pend_cnt_reg;
        pend_inst_next  = pend_inst_reg;
        pend_valid_next = pend_valid_reg;
        work_map_next   = work_map_reg;
        req_inst_next   = req_inst_reg;
        scan_idx_next   = scan_idx_reg;
        cnt_next        = cnt_reg;
        work_val_next   = work_val_reg;
        divisor_next    = divisor_reg;
        mod_second_next = mod_second_reg;
        switched_next   = switched_reg;
        status_next     = status_reg;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;

        if (out_valid_reg && res.ready)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_HOP_INCREMENT: hop_next = cfg_data[HOP_W-1:0];
                REG_INITIAL_MAP:   init_map_next = cfg_data;
                default:           hop_next = hop_reg;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    switched_next = 1'b0;
                    status_next   = 1'b0;
                    scan_idx_next = '0;
                    cnt_next      = '0;
                    case (req.data.command)
                        CMD_START:
                        begin
                            evt_next        = '0;
                            unmapped_next   = '0;
                            pend_valid_next = 1'b0;
                            work_map_next   = init_map_reg & CHAN_MASK;
                            op_next         = OP_START;
                            state_next      = ST_COUNT;
                        end
                        CMD_ADVANCE:
                        begin
                            evt_next = evt_inc;
                            if (pend_valid_reg && (evt_inc == pend_inst_reg))
                            begin
                                active_map_next = pend_map_reg;
                                active_cnt_next = pend_cnt_reg;
                                pend_valid_next = 1'b0;
                                switched_next   = 1'b1;
                            end
                            state_next = ST_HOP;
                        end
                        CMD_MAP_REQ:
                        begin
                            work_map_next = req.data.new_channel_map & CHAN_MASK;
                            req_inst_next = req.data.instant;
                            op_next       = OP_MAP;
                            state_next    = ST_COUNT;
                        end
                        default:
                        begin
                            state_next = ST_RESULT;
                        end
                    endcase
                end
            end

            // Popcount of the staged map, one channel per cycle.
            ST_COUNT:
            begin
                if (scan_bit)
                begin
                    cnt_next = cnt_reg + CH_W'(1);
                end
                if (scan_idx_reg == LAST_IDX)
                begin
                    state_next = ST_APPLY;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + CH_W'(1);
                end
            end

            ST_APPLY:
            begin
                if (cnt_reg == '0)
                begin
                    status_next = 1'b1;
                end
                if (op_reg == OP_START)
                begin
                    if (cnt_reg != '0)
                    begin
                        active_map_next = work_map_reg;
                        active_cnt_next = cnt_reg;
                    end
                    state_next = ST_HOP;
                end
                else
                begin
                    if (cnt_reg != '0)
                    begin
                        pend_map_next   = work_map_reg;
                        pend_cnt_next   = cnt_reg;
                        pend_inst_next  = req_inst_reg;
                        pend_valid_next = 1'b1;
                    end
                    state_next = ST_RESULT;
                end
            end

            ST_HOP:
            begin
                work_val_next   = (CH_W + 1)'(unmapped_reg) + (CH_W + 1)'(hop_reg);
                divisor_next    = NUM_CH;
                mod_second_next = 1'b0;
                state_next      = ST_MOD;
            end

            // Repeated subtraction: first the hop sum modulo the channel count,
            // then, for an unused channel, that channel modulo the used count.
            ST_MOD:
            begin
                if (sub_ge)
                begin
                    work_val_next = sub_res[CH_W:0];
                end
                else if (!mod_second_reg)
                begin
                    unmapped_next = work_val_reg[CH_W-1:0];
                    if (chan_used)
                    begin
                        mapped_next = work_val_reg[CH_W-1:0];
                        state_next  = ST_RESULT;
                    end
                    else if (active_cnt_reg == '0)
                    begin
                        state_next = ST_RESULT;
                    end
                    else
                    begin
                        divisor_next    = {1'b0, active_cnt_reg};
                        mod_second_next = 1'b1;
                    end
                end
                else
                begin
                    work_map_next = active_map_reg;
                    scan_idx_next = '0;
                    cnt_next      = '0;
                    state_next    = ST_FIND;
                end
            end

            // Walk the active map to the target-th used channel.
            ST_FIND:
            begin
                if (scan_bit && (cnt_reg == work_val_reg[CH_W-1:0]))
                begin
                    mapped_next = scan_idx_reg;
                    state_next  = ST_RESULT;
                end
                else
                begin
                    if (scan_bit)
                    begin
                        cnt_next = cnt_reg + CH_W'(1);
                    end
                    if (scan_idx_reg == LAST_IDX)
                    begin
                        state_next = ST_RESULT;
                    end
                    else
                    begin
                        scan_idx_next = scan_idx_reg + CH_W'(1);
                    end
                end
            end

            ST_RESULT:
            begin
                if (!out_valid_reg || res.ready)
                begin
                    out_data_next.data_channel = mapped_reg;
                    out_data_next.raw_channel  = unmapped_reg;
                    out_data_next.event_count  = evt_reg;
                    out_data_next.map_switched = switched_reg;
                    out_data_next.status       = status_reg;
                    out_valid_next             = 1'b1;
                    state_next                 = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            op_reg         <= OP_START;
            hop_reg        <= RESET_HOP;
            init_map_reg   <= {MAP_W{1'b1}};
            unmapped_reg   <= '0;
            mapped_reg     <= '0;
            evt_reg        <= '0;
            active_map_reg <= CHAN_MASK;
            active_cnt_reg <= RESET_COUNT;
            pend_map_reg   <= '0;
            pend_cnt_reg   <= '0;
            pend_inst_reg  <= '0;
            pend_valid_reg <= 1'b0;
            mod_second_reg <= 1'b0;
            switched_reg   <= 1'b0;
            status_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            op_reg         <= op_next;
            hop_reg        <= hop_next;
            init_map_reg   <= init_map_next;
            unmapped_reg   <= unmapped_next;
            mapped_reg     <= mapped_next;
            evt_reg        <= evt_next;
            active_map_reg <= active_map_next;
            active_cnt_reg <= active_cnt_next;
            pend_map_reg   <= pend_map_next;
            pend_cnt_reg   <= pend_cnt_next;
            pend_inst_reg  <= pend_inst_next;
            pend_valid_reg <= pend_valid_next;
            mod_second_reg <= mod_second_next;
            switched_reg   <= switched_next;
            status_reg     <= status_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Working payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        work_map_reg  <= work_map_next;
        req_inst_reg  <= req_inst_next;
        scan_idx_reg  <= scan_idx_next;
        cnt_reg       <= cnt_next;
        work_val_reg  <= work_val_next;
        divisor_reg   <= divisor_next;
        out_data_reg  <= out_data_next;
    end

endmodule
